// ----- sv/acp_pkg.sv -----
package acp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_mark;
    } acp_in_item_t;

    typedef struct packed {
        logic        parse_ok;
        logic [31:0] number_value;
        logic [2:0]  parse_status;
    } acp_out_item_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_PREFIX   = 3'd2;
    localparam logic [2:0] ST_BADCHAR  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [1:0] POS_MAX = 2'd3;

endpackage

// ----- sv/acp_in_stage.sv -----
module acp_in_stage
    import acp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  acp_in_item_t s_item,
    output logic         q_valid,
    input  logic         q_ready,
    output acp_in_item_t q_item
);

    logic         vld_reg;
    logic         vld_next;
    acp_in_item_t item_reg;
    logic         take;

    assign s_ready = !vld_reg || q_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        if (take) begin
            vld_next = 1'b1;
        end else if (q_ready) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = vld_reg;
    assign q_item  = item_reg;

endmodule

// ----- sv/acp_core.sv -----
module acp_core
    import acp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  acp_in_item_t  in_item,
    output logic          res_valid,
    input  logic          res_ready,
    output acp_out_item_t res_item
);

    logic [1:0]  pos_reg, pos_next;
    logic        hex_reg, hex_next;
    logic        dap_reg, dap_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  fail_reg, fail_next;

    logic        fire;
    logic [7:0]  c;
    logic [3:0]  digit;
    logic        digit_ok;
    logic        is_x;
    logic [35:0] prod;
    logic [35:0] sum;
    logic        ovf;
    logic [2:0]  status;

    assign c         = in_item.char_code;
    assign in_ready  = !in_item.end_mark || res_ready;
    assign fire      = in_valid && in_ready;
    assign res_valid = in_valid && in_item.end_mark;

    // digit decode
    always_comb begin
        digit    = 4'd0;
        digit_ok = 1'b0;
        case (c) inside
            [8'h30:8'h39]: begin
                digit    = 4'(c - 8'h30);
                digit_ok = 1'b1;
            end
            [8'h41:8'h46]: begin
                digit    = 4'(c - 8'h37);
                digit_ok = hex_reg;
            end
            [8'h61:8'h66]: begin
                digit    = 4'(c - 8'h57);
                digit_ok = hex_reg;
            end
            default: begin
                digit    = 4'd0;
                digit_ok = 1'b0;
            end
        endcase
    end

    assign is_x = (c == 8'h78) || (c == 8'h58);

    // value * base + digit, overflow when anything lands above bit 31
    assign prod = hex_reg ? {acc_reg, 4'b0000}
                          : ({1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0});
    assign sum  = prod + {32'd0, digit};
    assign ovf  = |sum[35:32];

    always_comb begin
        pos_next  = pos_reg;
        hex_next  = hex_reg;
        dap_next  = dap_reg;
        acc_next  = acc_reg;
        fail_next = fail_reg;
        if (fire) begin
            if (in_item.end_mark) begin
                pos_next  = 2'd0;
                hex_next  = 1'b0;
                dap_next  = 1'b0;
                acc_next  = 32'd0;
                fail_next = ST_OK;
            end else begin
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + 2'd1;
                end
                if (fail_reg == ST_OK) begin
                    if (pos_reg == 2'd1 && !hex_reg && acc_reg == 32'd0 && is_x) begin
                        hex_next = 1'b1;
                    end else begin
                        if (hex_reg) begin
                            dap_next = 1'b1;
                        end
                        if (!digit_ok) begin
                            fail_next = ST_BADCHAR;
                        end else if (ovf) begin
                            fail_next = ST_OVERFLOW;
                        end else begin
                            acc_next = sum[31:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 2'd0;
            hex_reg  <= 1'b0;
            dap_reg  <= 1'b0;
            acc_reg  <= 32'd0;
            fail_reg <= ST_OK;
        end else begin
            pos_reg  <= pos_next;
            hex_reg  <= hex_next;
            dap_reg  <= dap_next;
            acc_reg  <= acc_next;
            fail_reg <= fail_next;
        end
    end

    always_comb begin
        if (pos_reg == 2'd0) begin
            status = ST_EMPTY;
        end else if (fail_reg != ST_OK) begin
            status = fail_reg;
        end else if (hex_reg && !dap_reg) begin
            status = ST_PREFIX;
        end else begin
            status = ST_OK;
        end
    end

    assign res_item.parse_ok     = (status == ST_OK);
    assign res_item.number_value = (status == ST_OK) ? acc_reg : 32'd0;
    assign res_item.parse_status = status;

endmodule

// ----- sv/acp_out_stage.sv -----
module acp_out_stage
    import acp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          res_valid,
    output logic          res_ready,
    input  acp_out_item_t res_item,
    output logic          m_valid,
    input  logic          m_ready,
    output acp_out_item_t m_item
);

    logic          vld_reg;
    logic          vld_next;
    acp_out_item_t item_reg;
    logic          load;

    assign res_ready = !vld_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_comb begin
        if (load) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= res_item;
        end
    end

    assign m_valid = vld_reg;
    assign m_item  = item_reg;

endmodule

// ----- sv/ascii_u32_number_parser.sv -----
// ascii_u32_number_parser: parses one unsigned 32-bit number from a character stream
// input channel s_*: one transaction per character, s_item.char_code holds the
// ascii code; a transaction with s_item.end_mark set closes the token
// output channel m_*: one transaction per closed token with parse_ok,
// number_value (zero unless ok) and parse_status (0 ok, 1 empty,
// 2 "0x" prefix with no digits, 3 bad character, 4 overflow past 32 bits)
// a leading 0x or 0X selects hex, otherwise the token is decimal
// throughput: one character per cycle, end markers included, as long as
// m_ready is not held low
// an end marker taken at s_* passes through the input register, then the
// value and status go into the output register, which raises m_valid
// a stalled result holds in the output register; characters keep flowing
// until the next end marker reaches the core, then s_ready drops
// reset (aresetn low, synchronous) clears the token state and both valids
module ascii_u32_number_parser
    import acp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  acp_in_item_t  s_item,
    output logic          m_valid,
    input  logic          m_ready,
    output acp_out_item_t m_item
);

    logic          q_valid;
    logic          q_ready;
    acp_in_item_t  q_item;
    logic          res_valid;
    logic          res_ready;
    acp_out_item_t res_item;

    acp_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    acp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    acp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

`ifndef SYNTH
    a_ok_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.parse_ok == (m_item.parse_status == ST_OK)))
        else $error("parse_ok disagrees with parse_status");

    a_value_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.parse_ok) |-> (m_item.number_value == 32'd0))
        else $error("nonzero value on failed parse");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.parse_status == ST_OK || m_item.parse_status == ST_EMPTY
                     || m_item.parse_status == ST_PREFIX
                     || m_item.parse_status == ST_BADCHAR
                     || m_item.parse_status == ST_OVERFLOW))
        else $error("parse_status out of range");

    a_result_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |-> q_item.end_mark)
        else $error("result produced without end marker");
`endif

endmodule

// ----- tb/sv/tb_ascii_u32_number_parser.sv -----
`timescale 1ns / 100ps

module tb_ascii_u32_number_parser;
    import acp_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int QUIET_FROM   = 1200;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        acp_in_item_t  item;
        logic          typed;
        acp_out_item_t want;
    } dir_row_t;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    acp_in_item_t  s_item;
    logic          m_valid;
    logic          m_ready;
    acp_out_item_t m_item;

    logic          send_gaps   = 1'b1;
    logic          recv_stalls = 1'b1;
    int            items_sent  = 0;
    int            mismatches  = 0;
    int            cycle_count = 0;

    // token state of the predictor
    logic [1:0]    tok_pos        = '0;
    logic          tok_hex        = 1'b0;
    logic          tok_digit_seen = 1'b0;
    logic [31:0]   tok_value      = '0;
    logic [2:0]    tok_fail       = ST_OK;

    acp_out_item_t parse_results_due[$];
    acp_in_item_t  token_chars[$];

    dir_row_t dir_rows [23] = '{
        '{'{8'hA5, 1'b1}, 1'b1, '{1'b0, 32'd0, ST_EMPTY}},
        '{'{"0",   1'b0}, 1'b0, '0},
        '{'{"X",   1'b0}, 1'b0, '0},
        '{'{"0",   1'b1}, 1'b1, '{1'b0, 32'd0, ST_PREFIX}},
        '{'{"0",   1'b0}, 1'b0, '0},
        '{'{"x",   1'b0}, 1'b0, '0},
        '{'{"f",   1'b0}, 1'b0, '0},
        '{'{"F",   1'b0}, 1'b0, '0},
        '{'{"f",   1'b0}, 1'b0, '0},
        '{'{"F",   1'b0}, 1'b0, '0},
        '{'{"f",   1'b0}, 1'b0, '0},
        '{'{"F",   1'b0}, 1'b0, '0},
        '{'{"f",   1'b0}, 1'b0, '0},
        '{'{"F",   1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b1}, 1'b1, '{1'b1, 32'hFFFF_FFFF, ST_OK}},
        '{'{"1",   1'b0}, 1'b0, '0},
        '{'{"x",   1'b0}, 1'b0, '0},
        '{'{"x",   1'b1}, 1'b1, '{1'b0, 32'd0, ST_BADCHAR}},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b1}, 1'b1, '{1'b0, 32'd0, ST_BADCHAR}},
        '{'{"0",   1'b0}, 1'b0, '0},
        '{'{8'h5A, 1'b1}, 1'b1, '{1'b1, 32'd0, ST_OK}}
    };

    ascii_u32_number_parser i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic logic [4:0] digit_value(input logic [7:0] c, input logic hex);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (hex && c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
        if (hex && c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
        return 5'd16;
    endfunction

    task automatic parse_step(input acp_in_item_t it, output logic has_res,
                              output acp_out_item_t res);
        logic [1:0]  pos;
        logic [4:0]  d;
        logic [63:0] grown;
        logic [2:0]  status;
        has_res = 1'b0;
        res     = '0;
        if (!it.end_mark) begin
            pos = tok_pos;
            if (tok_pos != POS_MAX) tok_pos = tok_pos + 2'd1;
            if (tok_fail == ST_OK) begin
                if (pos == 2'd1 && !tok_hex && tok_value == '0 &&
                    (it.char_code == "x" || it.char_code == "X")) begin
                    tok_hex = 1'b1;
                end else begin
                    if (tok_hex) tok_digit_seen = 1'b1;
                    d     = digit_value(it.char_code, tok_hex);
                    grown = 64'(tok_value) * (tok_hex ? 64'd16 : 64'd10) + 64'(d);
                    if (d == 5'd16) tok_fail = ST_BADCHAR;
                    else if (grown > 64'hFFFF_FFFF) tok_fail = ST_OVERFLOW;
                    else tok_value = grown[31:0];
                end
            end
        end else begin
            if (tok_pos == 2'd0) status = ST_EMPTY;
            else if (tok_fail != ST_OK) status = tok_fail;
            else if (tok_hex && !tok_digit_seen) status = ST_PREFIX;
            else status = ST_OK;
            has_res          = 1'b1;
            res.parse_ok     = (status == ST_OK);
            res.number_value = (status == ST_OK) ? tok_value : '0;
            res.parse_status = status;
            tok_pos          = '0;
            tok_hex          = 1'b0;
            tok_digit_seen   = 1'b0;
            tok_value        = '0;
            tok_fail         = ST_OK;
        end
    endtask

    task automatic send_char(input acp_in_item_t it, input logic typed,
                             input acp_out_item_t want);
        logic          has_res;
        acp_out_item_t res;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        parse_step(it, has_res, res);
        if (has_res) parse_results_due.push_back(typed ? want : res);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic add_char(input logic [7:0] c);
        token_chars.push_back('{char_code: c, end_mark: 1'b0});
    endtask

    task automatic add_number(input logic hex, input int zeros);
        logic [63:0] v;
        logic [7:0]  digits[$];
        logic [3:0]  nib;
        case ($urandom_range(0, 5))
            0: v = 64'($urandom_range(0, 99));
            1: v = 64'($urandom >> $urandom_range(0, 31));
            2: v = 64'h0_FFFF_FFFF - 64'($urandom_range(0, 20));
            3: v = 64'h1_0000_0000 + 64'($urandom_range(0, 20));
            4: v = {24'd0, 8'($urandom), 32'($urandom)};
            default: v = 64'($urandom);
        endcase
        if (hex) begin
            add_char("0");
            if ($urandom_range(0, 1)) add_char("x");
            else add_char("X");
        end
        repeat (zeros) add_char("0");
        do begin
            if (hex) begin
                nib = v[3:0];
                if (nib < 4'd10) digits.push_front(8'("0" + nib));
                else if ($urandom_range(0, 1)) digits.push_front(8'("A" + nib - 4'd10));
                else digits.push_front(8'("a" + nib - 4'd10));
                v = v >> 4;
            end else begin
                digits.push_front(8'("0" + v % 10));
                v = v / 10;
            end
        end while (v != 0);
        foreach (digits[i]) add_char(digits[i]);
    endtask

    // result channel backpressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (recv_stalls && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        acp_out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (parse_results_due.size() == 0) begin
                $error("result transaction with none expected: %h", m_item);
                mismatches++;
            end else begin
                want = parse_results_due.pop_front();
                if (m_item.parse_ok !== want.parse_ok) begin
                    $error("parse_ok: expected %0d, got %0d", want.parse_ok, m_item.parse_ok);
                    mismatches++;
                end
                if (m_item.number_value !== want.number_value) begin
                    $error("number_value: expected %h, got %h",
                           want.number_value, m_item.number_value);
                    mismatches++;
                end
                if (m_item.parse_status !== want.parse_status) begin
                    $error("parse_status: expected %0d, got %0d",
                           want.parse_status, m_item.parse_status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_ascii_u32_number_parser NOT OK");
            $finish;
        end
    end

    initial begin
        int kind;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) send_char(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        while (items_sent < RANDOM_ITEMS + $size(dir_rows)) begin
            if (items_sent >= QUIET_FROM) begin
                send_gaps   = 1'b0;
                recv_stalls = 1'b0;
            end else begin
                send_gaps   = ($urandom_range(0, 3) != 0);
                recv_stalls = ($urandom_range(0, 3) != 0);
            end
            token_chars.delete();
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                add_number(1'b0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            end else if (kind < 60) begin
                add_number(1'b1, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            end else if (kind < 65) begin
                // empty token
            end else if (kind < 70) begin
                add_char("0");
                if ($urandom_range(0, 1)) add_char("x");
                else add_char("X");
            end else if (kind < 85) begin
                add_number(1'($urandom_range(0, 1)), 0);
                token_chars.insert($urandom_range(0, token_chars.size() - 1),
                                   '{char_code: 8'($urandom), end_mark: 1'b0});
            end else if (kind < 95) begin
                repeat ($urandom_range(1, 6)) add_char(8'($urandom));
            end else begin
                // long token: 15 to 30 leading zeros add length but not value
                add_number(1'($urandom_range(0, 1)), $urandom_range(15, 30));
            end
            token_chars.push_back('{char_code: 8'($urandom), end_mark: 1'b1});
            foreach (token_chars[i]) send_char(token_chars[i], 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (parse_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && parse_results_due.size() == 0) begin
            $display("tb_ascii_u32_number_parser OK");
        end else begin
            $display("tb_ascii_u32_number_parser NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/acp_pkg.sv
sv/acp_in_stage.sv
sv/acp_core.sv
sv/acp_out_stage.sv
sv/ascii_u32_number_parser.sv
tb/sv/tb_ascii_u32_number_parser.sv
